>>> src/sbf_pkg.sv
// sbf_pkg: shared types and constants of the sobel edge filter stream unit
// no dependencies; used by the top module, sbf_grad and sbf_isqrt
`default_nettype none

package sbf_pkg;

  // pixel and gradient widths fixed by the field definitions
  localparam int PIX_W   = 8;
  localparam int ABS_W   = 10;              // |gx|, |gy| up to 1020
  localparam int SQ_W    = 2 * ABS_W;       // one square
  localparam int VAL_W   = SQ_W + 1;        // sum of two squares
  localparam int ROOT_W  = 11;              // floor sqrt of VAL_W bits
  localparam int STEPS   = (VAL_W + 1) / 2; // one root bit per step

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // filter mode codes (any other code selects magnitude)
  localparam logic [1:0] MODE_HORZ = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_MAG  = 2'd2;

  // input item kind
  localparam logic IN_PIXEL = 1'b0;
  localparam logic IN_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // gradient results of one window
  typedef struct packed {
    pixel_t           gx_clip;
    pixel_t           gy_clip;
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
  } grad_t;

  // item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GRAD,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

>>> src/sobel_edge_filter_stream_unit.sv
// sobel_edge_filter_stream_unit: 3x3 sobel filter, uses sbf_pkg, sbf_ram, sbf_grad, sbf_isqrt
// flow: an input transfer passes load, grad and emit into the output register for gradient
// modes and border positions, with square, start and root (the square root unit) added for
// the magnitude; one item at a time, emit waits for a free output register, an item
// without a result returns from load to idle, and a drain tick in a frame stays in idle
// reset: filter_mode 2, width 640, height 480, counters and window cleared, ram kept
`default_nettype none

module sobel_edge_filter_stream_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [7:0]                      pixel_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [7:0]                      filtered_pixel_o,
  output logic                                 end_of_line_o,
  output logic                                 end_of_frame_o,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sbf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sbf_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * sbf_pkg::PIX_W;

  sbf_pkg::state_e state_q, state_d;

  // configuration registers
  logic [1:0]  filter_mode_q;
  logic [11:0] image_width_q;
  logic [12:0] image_height_q;

  // raster counters
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [COL_W-1:0] in_col_inc;

  // item registers
  sbf_pkg::pixel_t  pix_q;
  logic             drain_q;
  logic             emit_q;
  logic             wrap_q;
  logic             border_q;
  sbf_pkg::pixel_t  res_q;
  sbf_pkg::pixel_t  win_q [9];
  sbf_pkg::grad_t   grad;
  logic [sbf_pkg::ABS_W-1:0] abs_x_q, abs_y_q;
  logic [sbf_pkg::SQ_W-1:0]  sq_x_q, sq_y_q;

  // output register
  logic             out_valid_q;
  sbf_pkg::pixel_t  out_pix_q;
  logic             out_eol_q, out_eof_q;

  // effective dimensions, saturated to 3..MAX
  logic [31:0]      wid32, hgt32;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    wid32 = 32'(image_width_q);
    hgt32 = 32'(image_height_q);
    if (wid32 < 32'd3) begin
      wid32 = 32'd3;
    end else if (wid32 > 32'(MAX_WIDTH)) begin
      wid32 = 32'(MAX_WIDTH);
    end
    if (hgt32 < 32'd3) begin
      hgt32 = 32'd3;
    end else if (hgt32 > 32'(MAX_HEIGHT)) begin
      hgt32 = 32'(MAX_HEIGHT);
    end
    w_eff = wid32[COL_W-1:0];
    h_eff = hgt32[ROW_W-1:0];
  end

  // handshake terms
  logic in_xfer, cfg_xfer, out_free, drain_phase, in_drain, emit_now;
  logic restart;
  logic out_load;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign drain_phase = in_row_q >= h_eff;
  assign in_drain    = (mode_i == sbf_pkg::IN_DRAIN);
  assign emit_now    = (in_row_q >= ROW_W'(2)) ||
                       ((in_row_q == ROW_W'(1)) && (in_col_q >= COL_W'(1)));
  assign restart     = cfg_xfer && ((cfg_index_i == sbf_pkg::CFG_IMAGE_WIDTH) ||
                                    (cfg_index_i == sbf_pkg::CFG_IMAGE_HEIGHT));
  assign in_col_inc  = in_col_q + 1'b1;
  assign out_load    = (state_q == sbf_pkg::ST_EMIT) && out_free && !restart;

  // line store: upper line in the high byte, middle line in the low byte
  logic              ram_we, ram_re;
  logic [LINE_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] ram_addr;

  assign ram_addr = in_col_q[ADDR_W-1:0];

  sbf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i ({ram_rdata[sbf_pkg::PIX_W-1:0], pix_q}),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // gradients of the current window
  sbf_grad u_grad (
    .win_i  (win_q),
    .grad_o (grad)
  );

  // square root unit
  logic                         sqrt_start, sqrt_done;
  logic [sbf_pkg::ROOT_W-1:0]   sqrt_root;
  logic [sbf_pkg::VAL_W-1:0]    sq_sum;

  assign sq_sum = sbf_pkg::VAL_W'(sq_x_q) + sbf_pkg::VAL_W'(sq_y_q);

  sbf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_sum),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbf_pkg::ST_IDLE: begin
        if (in_xfer && !(!drain_phase && in_drain)) begin
          state_d = sbf_pkg::ST_LOAD;
        end
      end
      sbf_pkg::ST_LOAD: begin
        state_d = emit_q ? sbf_pkg::ST_GRAD : sbf_pkg::ST_IDLE;
      end
      sbf_pkg::ST_GRAD: begin
        if (border_q || filter_mode_q == sbf_pkg::MODE_HORZ ||
            filter_mode_q == sbf_pkg::MODE_VERT) begin
          state_d = sbf_pkg::ST_EMIT;
        end else begin
          state_d = sbf_pkg::ST_SQUARE;
        end
      end
      sbf_pkg::ST_SQUARE: state_d = sbf_pkg::ST_START;
      sbf_pkg::ST_START:  state_d = sbf_pkg::ST_ROOT;
      sbf_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_d = sbf_pkg::ST_EMIT;
        end
      end
      sbf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = sbf_pkg::ST_IDLE;
        end
      end
      default: state_d = sbf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    sqrt_start = 1'b0;
    case (state_q)
      sbf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i && !drain_phase;
      end
      sbf_pkg::ST_LOAD:  ram_we     = !drain_q;
      sbf_pkg::ST_START: sqrt_start = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, counters, window and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q  <= sbf_pkg::MODE_MAG;
      image_width_q  <= 12'd640;
      image_height_q <= 13'd480;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      // register writes
      if (cfg_xfer) begin
        case (cfg_index_i)
          sbf_pkg::CFG_FILTER_MODE:  filter_mode_q  <= cfg_data_i[1:0];
          sbf_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[11:0];
          sbf_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          default: begin
            filter_mode_q <= filter_mode_q;
          end
        endcase
      end

      // output register loads from the emit state and drains on transfer
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (restart) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        for (int i = 0; i < 9; i++) begin
          win_q[i] <= '0;
        end
      end else begin
        // shift the window and advance the input position
        if (state_q == sbf_pkg::ST_LOAD) begin
          if (!drain_q) begin
            for (int r = 0; r < 3; r++) begin
              win_q[r*3]   <= win_q[r*3+1];
              win_q[r*3+1] <= win_q[r*3+2];
            end
            win_q[2] <= ram_rdata[LINE_W-1:sbf_pkg::PIX_W];
            win_q[5] <= ram_rdata[sbf_pkg::PIX_W-1:0];
            win_q[8] <= pix_q;
            if (in_col_inc >= w_eff) begin
              in_col_q <= '0;
              in_row_q <= in_row_q + 1'b1;
            end else begin
              in_col_q <= in_col_inc;
            end
          end else if (in_col_inc > w_eff) begin
            in_col_q <= '0;
            in_row_q <= '0;
          end else begin
            in_col_q <= in_col_inc;
          end
        end

        // advance the output position with the result
        if (out_load) begin
          if (wrap_q) begin
            out_col_q <= '0;
            out_row_q <= '0;
          end else if (out_col_q + 1'b1 >= w_eff) begin
            out_col_q <= '0;
            if (out_row_q + 1'b1 >= h_eff) begin
              out_row_q <= '0;
            end else begin
              out_row_q <= out_row_q + 1'b1;
            end
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      sbf_pkg::ST_IDLE: begin
        pix_q   <= pixel_i;
        drain_q <= drain_phase;
        emit_q  <= emit_now;
      end
      sbf_pkg::ST_LOAD: begin
        wrap_q   <= drain_q && (in_col_inc > w_eff);
        border_q <= (out_row_q == '0) || (out_row_q >= h_eff - 1'b1) ||
                    (out_col_q == '0) || (out_col_q >= w_eff - 1'b1);
      end
      sbf_pkg::ST_GRAD: begin
        abs_x_q <= grad.abs_x;
        abs_y_q <= grad.abs_y;
        if (border_q) begin
          res_q <= '0;
        end else if (filter_mode_q == sbf_pkg::MODE_HORZ) begin
          res_q <= grad.gx_clip;
        end else begin
          res_q <= grad.gy_clip;
        end
      end
      sbf_pkg::ST_SQUARE: begin
        sq_x_q <= abs_x_q * abs_x_q;
        sq_y_q <= abs_y_q * abs_y_q;
      end
      sbf_pkg::ST_ROOT: begin
        res_q <= (sqrt_root > sbf_pkg::ROOT_W'(255)) ? 8'hff : sqrt_root[7:0];
      end
      sbf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_pix_q <= res_q;
          out_eol_q <= out_col_q >= w_eff - 1'b1;
          out_eof_q <= (out_col_q >= w_eff - 1'b1) && (out_row_q >= h_eff - 1'b1);
        end
      end
      default: begin
        pix_q <= pix_q;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_pixel_o = out_pix_q;
  assign end_of_line_o    = out_eol_q;
  assign end_of_frame_o   = out_eof_q;

endmodule

`default_nettype wire

>>> src/sbf_ram.sv
// sbf_ram: generic single write, single read synchronous ram
// registered read data, valid in the cycle after the read enable; no dependencies
`default_nettype none

module sbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/sbf_grad.sv
// sbf_grad: sobel gradients of a 3x3 window, clipped and absolute values
// depends on sbf_pkg
`default_nettype none

module sbf_grad (
  input  wire sbf_pkg::pixel_t win_i [9],
  output sbf_pkg::grad_t       grad_o
);

  logic [sbf_pkg::ABS_W-1:0] lft, rgt, top, bot;
  logic signed [sbf_pkg::ABS_W:0] gx, gy;
  logic signed [sbf_pkg::ABS_W:0] ngx, ngy;

  // weighted column and row sums, weights 1 2 1
  assign lft = 10'(win_i[0]) + {1'b0, win_i[3], 1'b0} + 10'(win_i[6]);
  assign rgt = 10'(win_i[2]) + {1'b0, win_i[5], 1'b0} + 10'(win_i[8]);
  assign top = 10'(win_i[0]) + {1'b0, win_i[1], 1'b0} + 10'(win_i[2]);
  assign bot = 10'(win_i[6]) + {1'b0, win_i[7], 1'b0} + 10'(win_i[8]);

  // left minus right, top minus bottom
  assign gx  = $signed({1'b0, lft}) - $signed({1'b0, rgt});
  assign gy  = $signed({1'b0, top}) - $signed({1'b0, bot});
  assign ngx = -gx;
  assign ngy = -gy;

  // clip to a byte and take magnitudes
  always_comb begin
    if (gx < 0) begin
      grad_o.gx_clip = '0;
      grad_o.abs_x   = ngx[sbf_pkg::ABS_W-1:0];
    end else begin
      grad_o.gx_clip = (gx > 255) ? 8'hff : gx[7:0];
      grad_o.abs_x   = gx[sbf_pkg::ABS_W-1:0];
    end
    if (gy < 0) begin
      grad_o.gy_clip = '0;
      grad_o.abs_y   = ngy[sbf_pkg::ABS_W-1:0];
    end else begin
      grad_o.gy_clip = (gy > 255) ? 8'hff : gy[7:0];
      grad_o.abs_y   = gy[sbf_pkg::ABS_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/sbf_isqrt.sv
// sbf_isqrt: iterative floor square root, one result bit per cycle
// depends on sbf_pkg
`default_nettype none

module sbf_isqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [sbf_pkg::VAL_W-1:0]    value_i,
  output logic                              done_o,
  output logic      [sbf_pkg::ROOT_W-1:0]   root_o
);

  localparam int CNT_W = $clog2(sbf_pkg::STEPS);

  logic [sbf_pkg::VAL_W-1:0] rem_q, rem_d;
  logic [sbf_pkg::VAL_W:0]   root_q, root_d;
  logic [sbf_pkg::VAL_W:0]   bit_q, bit_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [sbf_pkg::VAL_W+1:0] trial;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  // one digit step, or load on start
  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      root_d = '0;
      bit_d  = (sbf_pkg::VAL_W+1)'(1) << (2 * (sbf_pkg::STEPS - 1));
      cnt_d  = CNT_W'(sbf_pkg::STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({2'b00, rem_q} >= trial) begin
        rem_d  = rem_q - trial[sbf_pkg::VAL_W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[sbf_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire
